// File: src/banked_rom_page_mapper_core_defines.svh
// Assertion macros for the banked ROM page mapper.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BANKED_ROM_PAGE_MAPPER_CORE_DEFINES_SVH
`define BANKED_ROM_PAGE_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BRPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("brpm: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BRPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brpm: next-cycle check failed");

`endif

// File: src/brpm_pkg.sv
// Package of the banked ROM page mapper: field widths, operation codes and
// default geometry. No dependencies.
package brpm_pkg;

  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 16;
  localparam int BANK_NUM_W = 2;
  localparam int VALUE_W    = 10;
  localparam int OUT_WORD_W = 10;

  // Default geometry; PAGE_WORDS must be a power of two.
  localparam int PAGE_WORDS_DEF = 4096;
  localparam int PAGE_COUNT_DEF = 16;
  localparam int BANK_COUNT_DEF = 4;
  localparam int WORD_BITS_DEF  = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE_WORD = 2'd0,
    MODE_WRITE_FLAG = 2'd1,
    MODE_READ       = 2'd2,
    MODE_SELECT     = 2'd3
  } mode_e;

endpackage

// File: src/banked_rom_page_mapper_core.sv
// Banked ROM page mapper: paged program store with per-page bank select.
// A read passes the read stage, then the output register. Sustained rate is
// 1 item per cycle while nothing stalls, set by the single memory port.
// Reset starts a clearing pass over all PAGE_COUNT*BANK_COUNT*PAGE_WORDS
// entries (262144 by default) to word 0, flag 1; input stalls meanwhile.
// Depends on brpm_pkg and banked_rom_page_mapper_core_defines.svh.
`include "banked_rom_page_mapper_core_defines.svh"

module banked_rom_page_mapper_core
  import brpm_pkg::*;
#(
  parameter int PAGE_WORDS = PAGE_WORDS_DEF,
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int BANK_COUNT = BANK_COUNT_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [ADDR_W-1:0]     rom_address_i,
  input  logic [BANK_NUM_W-1:0] bank_number_i,
  input  logic [VALUE_W-1:0]    write_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OUT_WORD_W-1:0] rom_word_o,
  output logic                  break_flag_o
);

  localparam int OFFS_W    = $clog2(PAGE_WORDS);
  localparam int PG_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ROW_CNT   = PAGE_COUNT * BANK_COUNT;
  localparam int ROW_W     = (ROW_CNT > 1) ? $clog2(ROW_CNT) : 1;
  localparam int MEM_DEPTH = ROW_CNT * PAGE_WORDS;
  localparam int MEM_AW    = ROW_W + OFFS_W;

  // ---------------------------------------------------------------------
  // Clearing pass: sweep the word and flag memories once after reset.
  // ---------------------------------------------------------------------
  logic              clr_busy_q;
  logic [MEM_AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: a read occupies the read stage, then the output register.
  // Take a new transfer only when the read stage is free or moving on.
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  logic s1_oob_q;
  logic out_valid_q;
  logic s1_adv;
  logic in_fire;
  mode_e mode;

  assign mode       = mode_e'(mode_i);
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_busy_q || (s1_valid_q && !s1_adv);
  assign in_fire    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------
  // Address decode: page and offset from the address, bank from the input
  // on writes and selects, from the page's active bank on reads.
  // ---------------------------------------------------------------------
  logic [BANK_NUM_W-1:0] sel_bank_q [PAGE_COUNT];
  logic [ROW_CNT-1:0]    present_q;

  logic [ADDR_W-1:0]     page_full;
  logic [PG_W-1:0]       page_idx;
  logic [OFFS_W-1:0]     offset;
  logic                  page_ok;
  logic                  bank_ok;
  logic [BANK_NUM_W-1:0] bank_use;
  logic [ROW_W-1:0]      row;
  logic [ROW_W-1:0]      row_wr;

  assign page_full = ADDR_W'(rom_address_i >> OFFS_W);
  assign page_idx  = page_full[PG_W-1:0];
  assign offset    = rom_address_i[OFFS_W-1:0];
  assign page_ok   = 32'(page_full) < PAGE_COUNT;
  assign bank_ok   = 32'(bank_number_i) < BANK_COUNT;

  always_comb begin
    bank_use = bank_number_i;
    if (mode == MODE_READ && page_ok) begin
      bank_use = sel_bank_q[page_idx];
    end
  end

  assign row    = ROW_W'(32'(page_idx) * BANK_COUNT + 32'(bank_use));
  assign row_wr = ROW_W'(32'(page_idx) * BANK_COUNT + 32'(bank_number_i));

  logic wr_ok;
  logic wr_word;
  logic wr_flag;
  logic do_select;
  logic rd_issue;

  assign wr_ok     = in_fire && page_ok && bank_ok;
  assign wr_word   = wr_ok && (mode == MODE_WRITE_WORD);
  assign wr_flag   = wr_ok && (mode == MODE_WRITE_FLAG);
  assign do_select = wr_ok && (mode == MODE_SELECT) && present_q[row_wr];
  assign rd_issue  = in_fire && (mode == MODE_READ);

  // Mark a bank present on any write; switch only to a present bank.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      for (int p = 0; p < PAGE_COUNT; p++) begin
        sel_bank_q[p] <= '0;
      end
    end else begin
      if (wr_word || wr_flag) begin
        present_q[row_wr] <= 1'b1;
      end
      if (do_select) begin
        sel_bank_q[page_idx] <= bank_number_i;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Word and flag memories: one shared address, registered read data.
  // ---------------------------------------------------------------------
  logic [WORD_BITS-1:0] word_mem [MEM_DEPTH];
  logic                 flag_mem [MEM_DEPTH];
  logic [MEM_AW-1:0]    mem_addr;
  logic [WORD_BITS-1:0] mem_wword;
  logic                 mem_wflag;
  logic                 word_we;
  logic                 flag_we;
  logic [31:0]          value_ext;
  logic [WORD_BITS-1:0] rd_word_q;
  logic                 rd_flag_q;

  assign value_ext = 32'(write_value_i);
  assign mem_addr  = clr_busy_q ? clr_cnt_q : {row, offset};
  assign mem_wword = clr_busy_q ? '0 : value_ext[WORD_BITS-1:0];
  assign mem_wflag = clr_busy_q ? 1'b1 : write_value_i[0];
  assign word_we   = clr_busy_q || wr_word;
  assign flag_we   = clr_busy_q || wr_flag;

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[mem_addr] <= mem_wword;
    end
    if (rd_issue) begin
      rd_word_q <= word_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[mem_addr] <= mem_wflag;
    end
    if (rd_issue) begin
      rd_flag_q <= flag_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Read stage and output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_oob_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= rd_issue;
        s1_oob_q   <= !page_ok;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [OUT_WORD_W-1:0] rom_word_q;
  logic                  break_flag_q;
  logic [31:0]           rd_word_ext;

  assign rd_word_ext = 32'(rd_word_q);

  // Force an out-of-range page to word 0, flag 1.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rom_word_q   <= s1_oob_q ? '0 : rd_word_ext[OUT_WORD_W-1:0];
      break_flag_q <= s1_oob_q ? 1'b1 : rd_flag_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rom_word_o   = rom_word_q;
  assign break_flag_o = break_flag_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `BRPM_ASSERT_NOW(a_stall_in_clear, clr_busy_q, in_stall_o)
  `BRPM_ASSERT_NEXT(a_read_enters_s1, rd_issue, s1_valid_q)
  `BRPM_ASSERT_NEXT(a_other_leaves_s1_empty, in_fire && !rd_issue, !s1_valid_q)
  `BRPM_ASSERT_NEXT(a_s1_held_on_stall, s1_valid_q && out_valid_q && out_stall_i, s1_valid_q)

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench of banked_rom_page_mapper_core: directed and random ROM operations,
// results checked against a paged, banked store kept here. Needs brpm_pkg.

module tb;
  import brpm_pkg::*;

  // Longest correct stretch without a transfer is the clearing pass after reset;
  // the watchdog limit is set above it.
  localparam int CLEAR_CYCLES   = PAGE_COUNT_DEF * BANK_COUNT_DEF * PAGE_WORDS_DEF;
  localparam int WATCHDOG_LIMIT = 3 * CLEAR_CYCLES + 10000;
  localparam int RANDOM_OPS     = 800;
  localparam int HOT_COUNT      = 24;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_HOLD      = 600;

  typedef struct packed {
    mode_e                 mode;
    logic [ADDR_W-1:0]     addr;
    logic [BANK_NUM_W-1:0] bank;
    logic [VALUE_W-1:0]    value;
  } rom_op_t;

  typedef struct packed {
    logic [OUT_WORD_W-1:0] word;
    logic                  flag;
  } rom_read_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [MODE_W-1:0]     mode_i = '0;
  logic [ADDR_W-1:0]     rom_address_i = '0;
  logic [BANK_NUM_W-1:0] bank_number_i = '0;
  logic [VALUE_W-1:0]    write_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [OUT_WORD_W-1:0] rom_word_o;
  logic                  break_flag_o;

  banked_rom_page_mapper_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .rom_address_i (rom_address_i),
    .bank_number_i (bank_number_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rom_word_o    (rom_word_o),
    .break_flag_o  (break_flag_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow ROM: sparse word and flag stores, present bits per page and bank, and the
  // active bank of each page. Entries never written read back as word 0, flag 1.
  // ---------------------------------------------------------------------------
  bit [OUT_WORD_W-1:0] shadow_word [int];
  bit                  shadow_flag [int];
  bit                  bank_loaded [PAGE_COUNT_DEF * BANK_COUNT_DEF];
  bit [BANK_NUM_W-1:0] shadow_sel [PAGE_COUNT_DEF];

  rom_op_t   op_queue [$];     // operations waiting to be offered
  rom_read_t read_expect_q [$]; // read results still owed by the block

  int ops_total = 0;
  int ops_done = 0;
  int fail_count = 0;
  int reads_seen = 0;

  // Apply one accepted operation to the shadow ROM; a read queues its result.
  function automatic void apply_rom_op(rom_op_t op);
    int        page;
    int        offset;
    int        slot;
    int        active;
    rom_read_t rd;
    page   = op.addr / PAGE_WORDS_DEF;
    offset = op.addr % PAGE_WORDS_DEF;
    if (op.mode == MODE_READ) begin
      rd.word = '0;
      rd.flag = 1'b1;
      if (page < PAGE_COUNT_DEF) begin
        active = shadow_sel[page];
        if (active < BANK_COUNT_DEF) begin
          slot = (page * BANK_COUNT_DEF + active) * PAGE_WORDS_DEF + offset;
          if (shadow_word.exists(slot)) rd.word = shadow_word[slot];
          if (shadow_flag.exists(slot)) rd.flag = shadow_flag[slot];
        end
      end
      read_expect_q.push_back(rd);
      return;
    end
    // Drop writes and selects that fall outside the page or bank range.
    if (page >= PAGE_COUNT_DEF || op.bank >= BANK_COUNT_DEF) return;
    slot = (page * BANK_COUNT_DEF + op.bank) * PAGE_WORDS_DEF + offset;
    case (op.mode)
      MODE_WRITE_WORD: begin
        shadow_word[slot] = op.value & ((1 << WORD_BITS_DEF) - 1);
        bank_loaded[page * BANK_COUNT_DEF + op.bank] = 1'b1;
      end
      MODE_WRITE_FLAG: begin
        shadow_flag[slot] = op.value[0];
        bank_loaded[page * BANK_COUNT_DEF + op.bank] = 1'b1;
      end
      default: begin
        // Switch only to a bank that holds something.
        if (bank_loaded[page * BANK_COUNT_DEF + op.bank]) shadow_sel[page] = op.bank;
      end
    endcase
  endfunction

  function automatic void add_op(mode_e mode, int addr, int bank, int value);
    rom_op_t op;
    op.mode  = mode;
    op.addr  = addr[ADDR_W-1:0];
    op.bank  = bank[BANK_NUM_W-1:0];
    op.value = value[VALUE_W-1:0];
    op_queue.push_back(op);
    ops_total++;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer operations in bursts of random length with random gaps.
  // Hold the payload while stalled; predict on each input transfer.
  // ---------------------------------------------------------------------------
  int      burst_left = 1;
  int      gap_left = 0;
  rom_op_t next_op;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && in_stall_o) begin
      // Hold: the block has not taken the current item yet.
    end else begin
      if (in_valid_i) begin
        apply_rom_op(rom_op_t'{mode_e'(mode_i), rom_address_i, bank_number_i, write_value_i});
        ops_done++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (op_queue.size() != 0) begin
        next_op = op_queue.pop_front();
        mode_i        <= next_op.mode;
        rom_address_i <= next_op.addr;
        bank_number_i <= next_op.bank;
        write_value_i <= next_op.value;
        in_valid_i    <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          // End the burst; leave no gap about a quarter of the time.
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: phases with their own stall rate, plus one long hold-off
  // that lets the block fill up and push back on its input.
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int phase_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (!hold_done && reads_seen >= 120) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 90;
          endcase
        end
        phase_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each output transfer with the oldest owed read.
  // ---------------------------------------------------------------------------
  rom_read_t owed;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reads_seen <= reads_seen + 1;
      if (read_expect_q.size() == 0) begin
        $error("unexpected result: rom_word %0h, break_flag %0b", rom_word_o, break_flag_o);
        fail_count++;
      end else begin
        owed = read_expect_q.pop_front();
        if (rom_word_o !== owed.word) begin
          $error("rom_word: expected %0h, actual %0h", owed.word, rom_word_o);
          fail_count++;
        end
        if (break_flag_o !== owed.flag) begin
          $error("break_flag: expected %0b, actual %0b", owed.flag, break_flag_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run after too long without any transfer.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] hot_addr [HOT_COUNT];

  initial begin
    int    r;
    int    addr;
    mode_e mode;

    // Directed: field extremes, absent banks, refused selects, flag writes.
    add_op(MODE_WRITE_WORD, 16'h0000, 0, 10'h3FF);
    add_op(MODE_WRITE_WORD, 16'hFFFF, 3, 10'h3FF);
    add_op(MODE_READ,       16'h0000, 3, 10'h000);  // bank field ignored on read
    add_op(MODE_READ,       16'hFFFF, 0, 10'h3FF);  // active bank 0 absent
    add_op(MODE_SELECT,     16'hF000, 2, 10'h000);  // bank 2 absent: refused
    add_op(MODE_READ,       16'hFFFF, 1, 10'h000);
    add_op(MODE_SELECT,     16'hF123, 3, 10'h3FF);  // bank 3 present: taken
    add_op(MODE_READ,       16'hFFFF, 2, 10'h155);
    add_op(MODE_WRITE_FLAG, 16'hFFFF, 3, 10'h3FE);  // flag bit 0 clear
    add_op(MODE_READ,       16'hFFFF, 0, 10'h000);
    add_op(MODE_WRITE_FLAG, 16'h0001, 0, 10'h001);
    add_op(MODE_WRITE_FLAG, 16'h0002, 0, 10'h000);
    add_op(MODE_READ,       16'h0002, 0, 10'h000);
    add_op(MODE_WRITE_WORD, 16'h8ABC, 1, 10'h155);
    add_op(MODE_WRITE_WORD, 16'h8ABC, 1, 10'h2AA);  // overwrite
    add_op(MODE_SELECT,     16'h8000, 1, 10'h000);
    add_op(MODE_READ,       16'h8ABC, 0, 10'h000);
    add_op(MODE_READ,       16'h8ABD, 0, 10'h000);  // present bank, blank entry
    add_op(MODE_SELECT,     16'h8FFF, 0, 10'h000);  // bank 0 of page 8 absent
    add_op(MODE_READ,       16'h8ABC, 3, 10'h000);
    add_op(MODE_WRITE_WORD, 16'h7FFF, 2, 10'h000);
    add_op(MODE_READ,       16'h7FFF, 2, 10'h000);

    // A small pool of addresses keeps writes, selects and reads colliding.
    hot_addr[0] = 16'h0000;
    hot_addr[1] = 16'hFFFF;
    for (int i = 2; i < HOT_COUNT; i++) begin
      hot_addr[i] = {4'($urandom_range(0, 15)), 12'($urandom_range(0, 7) * 512)};
      if ($urandom_range(0, 1)) hot_addr[i][11:0] = 12'($urandom_range(0, 4095));
    end

    for (int i = 0; i < RANDOM_OPS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      mode = MODE_WRITE_WORD;
      else if (r < 45) mode = MODE_WRITE_FLAG;
      else if (r < 78) mode = MODE_READ;
      else             mode = MODE_SELECT;
      if ($urandom_range(0, 99) < 80) addr = hot_addr[$urandom_range(0, HOT_COUNT - 1)];
      else                            addr = $urandom_range(0, 16'hFFFF);
      add_op(mode, addr, $urandom_range(0, 3), $urandom_range(0, 1023));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample on the falling edge so the counts are settled.
    while (ops_done != ops_total) @(negedge clk_i);
    while (read_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
